FILE: design/lti_pkg.sv
// Shared types, widths and constants of the table-interpolated activation unit.
`default_nettype none

package lti_pkg;

    // Table store geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_AW      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

    // Field and register widths.
    localparam int DATA_W      = 32;
    localparam int SCALE_W     = 24;
    localparam int LAST_W      = 10;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 17;
    localparam int POS_W       = 24;
    localparam int FRAC_W      = 16;
    localparam int MAGPROD_W   = DATA_W + SCALE_W;
    localparam int INTERP_W    = 2 * VAL_W;
    localparam int ACT_W       = VAL_W + 1;
    localparam int PROD_W      = ACT_W + DATA_W;
    localparam int Q_W         = PROD_W - FRAC_W;

    // Number of register stages from input to output.
    localparam int NUM_STAGES  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE      = 2'd0,
        CFG_TABLE_LAST = 2'd1,
        CFG_ACT_KIND   = 2'd2,
        CFG_APPLY_MUL  = 2'd3
    } cfg_index_t;

    localparam logic OP_EVAL       = 1'b0;
    localparam logic OP_LOAD       = 1'b1;
    localparam logic KIND_TANH     = 1'b0;
    localparam logic KIND_LOGISTIC = 1'b1;

    localparam logic [VAL_W-1:0]   ONE_Q16        = 17'h10000;
    localparam logic [SCALE_W-1:0] SCALE_RESET    = 24'h010000;
    localparam logic [LAST_W-1:0]  LAST_RESET     = 10'd1023;
    localparam logic [DATA_W-1:0]  RESULT_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  RESULT_MIN     = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: design/lut_interp_tanh_logistic.sv
// Top level of the table-interpolated tanh / logistic activation unit.
//
// Accepts one beat per cycle while in_stall is low and delivers one result beat per
// evaluate beat, from the saturating output register; load beats update the table store
// and deliver nothing. The pipeline has eight stages: an absolute value stage, the 32x24
// position multiply, the range compare, the table store read (one write port, two read
// ports), the 17x17 and 17x16 interpolation multiplies, sign and logistic correction,
// the 18x32 multiplier product and the saturating output register. Each stage holds
// while the one after it is full and stalled. A load writes the store in the same stage
// where an evaluate reads it, so results always see every earlier load. The store is
// not cleared after reset.
`default_nettype none

module lut_interp_tanh_logistic
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [lti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lti_pkg::CFG_W-1:0]       cfg_data,
    // Input channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic signed [lti_pkg::DATA_W-1:0] sample,
    input  wire logic signed [lti_pkg::DATA_W-1:0] multiplier,
    input  wire logic [lti_pkg::IDX_W-1:0]       table_index,
    input  wire logic [lti_pkg::VAL_W-1:0]       table_value,
    input  wire logic                            end_of_vector,
    // Output channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [lti_pkg::DATA_W-1:0]    result,
    output logic                                 clipped,
    output logic                                 overflow,
    output logic                                 end_marker
);

    import lti_pkg::*;

    // Configuration registers.
    logic [SCALE_W-1:0] scale_reg;
    logic [LAST_W-1:0]  table_last_reg;
    logic               act_kind_reg;
    logic               apply_mul_reg;

    // Stage control.
    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;
    logic [NUM_STAGES+1:1] stage_en;

    // Stage 1: captured beat with magnitude.
    logic                     s1_op_reg;
    logic                     s1_neg_reg;
    logic [DATA_W-1:0]        s1_mag_reg;
    logic signed [DATA_W-1:0] s1_mul_reg;
    logic [IDX_W-1:0]         s1_widx_reg;
    logic [VAL_W-1:0]         s1_wval_reg;
    logic                     s1_eov_reg;
    logic [DATA_W-1:0]        s1_mag_next;

    // Stage 2: table position.
    logic                     s2_op_reg;
    logic                     s2_neg_reg;
    logic [POS_W-1:0]         s2_idx_reg;
    logic [FRAC_W-1:0]        s2_frac_reg;
    logic signed [DATA_W-1:0] s2_mul_reg;
    logic [IDX_W-1:0]         s2_widx_reg;
    logic [VAL_W-1:0]         s2_wval_reg;
    logic                     s2_eov_reg;
    logic [MAGPROD_W-1:0]     s2_pos_next;

    // Stage 3: store addresses and range flags.
    logic                     s3_op_reg;
    logic                     s3_neg_reg;
    logic                     s3_clip_reg;
    logic [TBL_AW-1:0]        s3_addr0_reg;
    logic [TBL_AW-1:0]        s3_addr1_reg;
    logic                     s3_zero0_reg;
    logic                     s3_zero1_reg;
    logic [FRAC_W-1:0]        s3_frac_reg;
    logic signed [DATA_W-1:0] s3_mul_reg;
    logic [TBL_AW-1:0]        s3_waddr_reg;
    logic                     s3_wok_reg;
    logic [VAL_W-1:0]         s3_wval_reg;
    logic                     s3_eov_reg;

    // Stage 4: table store read data.
    logic [VAL_W-1:0]         tbl_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]         s4_l0_reg;
    logic [VAL_W-1:0]         s4_l1_reg;
    logic                     s4_zero0_reg;
    logic                     s4_zero1_reg;
    logic                     s4_neg_reg;
    logic                     s4_clip_reg;
    logic [FRAC_W-1:0]        s4_frac_reg;
    logic signed [DATA_W-1:0] s4_mul_reg;
    logic                     s4_eov_reg;
    logic                     tbl_write;

    // Stage 5: interpolation products.
    logic [INTERP_W-1:0]      s5_p0_reg;
    logic [INTERP_W-1:0]      s5_p1_reg;
    logic                     s5_neg_reg;
    logic                     s5_clip_reg;
    logic signed [DATA_W-1:0] s5_mul_reg;
    logic                     s5_eov_reg;
    logic [VAL_W-1:0]         l0_masked;
    logic [VAL_W-1:0]         l1_masked;
    logic [VAL_W-1:0]         frac_comp;

    // Stage 6: signed activation.
    logic signed [ACT_W-1:0]  s6_act_reg;
    logic                     s6_clip_reg;
    logic signed [DATA_W-1:0] s6_mul_reg;
    logic                     s6_eov_reg;
    logic [INTERP_W:0]        interp_sum;
    logic [VAL_W-1:0]         interp_val;
    logic signed [ACT_W-1:0]  mag_val;
    logic signed [ACT_W-1:0]  s6_act_next;

    // Stage 7: multiplier product.
    logic signed [PROD_W-1:0] s7_prod_reg;
    logic signed [ACT_W-1:0]  s7_act_reg;
    logic                     s7_clip_reg;
    logic                     s7_eov_reg;
    logic signed [PROD_W-1:0] s7_prod_next;

    // Stage 8: output register.
    logic signed [DATA_W-1:0] result_reg;
    logic                     clipped_reg;
    logic                     overflow_reg;
    logic                     end_marker_reg;
    logic signed [Q_W-1:0]    quot;
    logic                     quot_fits;
    logic signed [DATA_W-1:0] result_next;
    logic                     overflow_next;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RESET;
            table_last_reg <= LAST_RESET;
            act_kind_reg   <= KIND_TANH;
            apply_mul_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                CFG_TABLE_LAST: table_last_reg <= cfg_data[LAST_W-1:0];
                CFG_ACT_KIND:   act_kind_reg   <= cfg_data[0];
                CFG_APPLY_MUL:  apply_mul_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or the next one loads.
    // ------------------------------------------------------------------
    always_comb
    begin
        stage_en[NUM_STAGES+1] = !out_stall;
        for (int i = NUM_STAGES; i >= 1; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        vld_next[1] = in_valid;
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
        // Load beats end at the store write.
        vld_next[4] = vld_reg[3] && (s3_op_reg == OP_EVAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign in_stall  = !stage_en[1];
    assign out_valid = vld_reg[NUM_STAGES];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    // The magnitude of the most negative sample is 2^31, which still fits unsigned.
    assign s1_mag_next = sample[DATA_W-1] ? (~sample + 1'b1) : sample;

    assign s2_pos_next = MAGPROD_W'(s1_mag_reg) * MAGPROD_W'(scale_reg);

    assign tbl_write = vld_reg[3] && (s3_op_reg == OP_LOAD) && s3_wok_reg && stage_en[4];

    assign l0_masked = s4_zero0_reg ? '0 : s4_l0_reg;
    assign l1_masked = s4_zero1_reg ? '0 : s4_l1_reg;
    assign frac_comp = ONE_Q16 - VAL_W'(s4_frac_reg);

    assign interp_sum = (INTERP_W+1)'(s5_p0_reg) + (INTERP_W+1)'(s5_p1_reg);
    assign interp_val = s5_clip_reg ? ONE_Q16 : interp_sum[FRAC_W +: VAL_W];
    assign mag_val    = signed'({1'b0, interp_val});

    always_comb
    begin
        if (!s5_neg_reg)
        begin
            s6_act_next = mag_val;
        end
        else if (act_kind_reg == KIND_LOGISTIC)
        begin
            s6_act_next = signed'({1'b0, ONE_Q16}) - mag_val;
        end
        else
        begin
            s6_act_next = -mag_val;
        end
    end

    assign s7_prod_next = s6_act_reg * s6_mul_reg;

    // An arithmetic shift of the product floors toward minus infinity.
    assign quot      = s7_prod_reg[PROD_W-1:FRAC_W];
    assign quot_fits = (quot[Q_W-1:DATA_W-1] == '0) || (quot[Q_W-1:DATA_W-1] == '1);

    always_comb
    begin
        if (!apply_mul_reg)
        begin
            result_next   = DATA_W'(s7_act_reg);
            overflow_next = 1'b0;
        end
        else if (quot_fits)
        begin
            result_next   = quot[DATA_W-1:0];
            overflow_next = 1'b0;
        end
        else
        begin
            result_next   = quot[Q_W-1] ? RESULT_MIN : RESULT_MAX;
            overflow_next = 1'b1;
        end
    end

    // Table store: one write port and two read ports, read data registered.
    always_ff @(posedge clk)
    begin
        if (tbl_write)
        begin
            tbl_mem[s3_waddr_reg] <= s3_wval_reg;
        end
        if (stage_en[4])
        begin
            s4_l0_reg <= tbl_mem[s3_addr0_reg];
            s4_l1_reg <= tbl_mem[s3_addr1_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_op_reg   <= operation;
            s1_neg_reg  <= sample[DATA_W-1];
            s1_mag_reg  <= s1_mag_next;
            s1_mul_reg  <= multiplier;
            s1_widx_reg <= table_index;
            s1_wval_reg <= table_value;
            s1_eov_reg  <= end_of_vector;
        end
        if (stage_en[2])
        begin
            s2_op_reg   <= s1_op_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_idx_reg  <= s2_pos_next[MAGPROD_W-1 -: POS_W];
            s2_frac_reg <= s2_pos_next[FRAC_W +: FRAC_W];
            s2_mul_reg  <= s1_mul_reg;
            s2_widx_reg <= s1_widx_reg;
            s2_wval_reg <= s1_wval_reg;
            s2_eov_reg  <= s1_eov_reg;
        end
        if (stage_en[3])
        begin
            s3_op_reg    <= s2_op_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_clip_reg  <= (s2_idx_reg >= POS_W'(table_last_reg));
            s3_addr0_reg <= TBL_AW'(s2_idx_reg);
            s3_addr1_reg <= TBL_AW'(s2_idx_reg + 1'b1);
            s3_zero0_reg <= (s2_idx_reg >= POS_W'(TABLE_DEPTH));
            s3_zero1_reg <= (s2_idx_reg >= POS_W'(TABLE_DEPTH - 1));
            s3_frac_reg  <= s2_frac_reg;
            s3_mul_reg   <= s2_mul_reg;
            s3_waddr_reg <= TBL_AW'(s2_widx_reg);
            s3_wok_reg   <= (32'(s2_widx_reg) < 32'(TABLE_DEPTH));
            s3_wval_reg  <= s2_wval_reg;
            s3_eov_reg   <= s2_eov_reg;
        end
        if (stage_en[4])
        begin
            s4_zero0_reg <= s3_zero0_reg;
            s4_zero1_reg <= s3_zero1_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_clip_reg  <= s3_clip_reg;
            s4_frac_reg  <= s3_frac_reg;
            s4_mul_reg   <= s3_mul_reg;
            s4_eov_reg   <= s3_eov_reg;
        end
        if (stage_en[5])
        begin
            s5_p0_reg   <= INTERP_W'(l0_masked) * INTERP_W'(frac_comp);
            s5_p1_reg   <= INTERP_W'(l1_masked) * INTERP_W'(s4_frac_reg);
            s5_neg_reg  <= s4_neg_reg;
            s5_clip_reg <= s4_clip_reg;
            s5_mul_reg  <= s4_mul_reg;
            s5_eov_reg  <= s4_eov_reg;
        end
        if (stage_en[6])
        begin
            s6_act_reg  <= s6_act_next;
            s6_clip_reg <= s5_clip_reg;
            s6_mul_reg  <= s5_mul_reg;
            s6_eov_reg  <= s5_eov_reg;
        end
        if (stage_en[7])
        begin
            s7_prod_reg <= s7_prod_next;
            s7_act_reg  <= s6_act_reg;
            s7_clip_reg <= s6_clip_reg;
            s7_eov_reg  <= s6_eov_reg;
        end
        if (stage_en[8])
        begin
            result_reg     <= result_next;
            clipped_reg    <= s7_clip_reg;
            overflow_reg   <= overflow_next;
            end_marker_reg <= s7_eov_reg;
        end
    end

    assign result     = result_reg;
    assign clipped    = clipped_reg;
    assign overflow   = overflow_reg;
    assign end_marker = end_marker_reg;

endmodule

`default_nettype wire

FILE: design/lti_checker.sv
// Port-level assertions for the activation unit and the bind that attaches them.
`default_nettype none

module lti_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              operation,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic signed [lti_pkg::DATA_W-1:0] result,
    input  wire logic                              clipped,
    input  wire logic                              overflow,
    input  wire logic                              end_marker
);

    import lti_pkg::*;

    localparam int PEND_W = $clog2(NUM_STAGES + 1);

    // Evaluate beats accepted but not yet delivered.
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic              eval_in;
    logic              res_out;

    assign eval_in = in_valid && !in_stall && (operation == OP_EVAL);
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (eval_in && !res_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!eval_in && res_out)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(clipped)
            && $stable(overflow) && $stable(end_marker))
        else $error("stalled result beat changed");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> result == RESULT_MAX || result == RESULT_MIN)
        else $error("overflow flagged on an unsaturated result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result beat without a pending evaluate beat");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(NUM_STAGES))
        else $error("more evaluate beats in flight than pipeline stages");

endmodule

bind lut_interp_tanh_logistic lti_checker u_lti_checker (.*);

`default_nettype wire
